// ----- rtl/iksg_pkg.sv -----
package iksg_pkg;

    localparam int          POOL_LOG2_DEF = 8;
    localparam logic [31:0] GOLDEN        = 32'h9e37_79b9;

    typedef enum logic [4:0] {
        UOP_NONE     = 5'd0,
        UOP_SEED_WR  = 5'd1,
        UOP_INIT_CLR = 5'd2,
        UOP_SCR_ROW  = 5'd3,
        UOP_LD_RD    = 5'd4,
        UOP_LD_ADD   = 5'd5,
        UOP_ST       = 5'd6,
        UOP_MP_START = 5'd7,
        UOP_MP1      = 5'd8,
        UOP_MP2      = 5'd9,
        UOP_MP3      = 5'd10,
        UOP_MP4      = 5'd11,
        UOP_MP5      = 5'd12,
        UOP_MP6      = 5'd13,
        UOP_MP_END   = 5'd14,
        UOP_CLR_WR   = 5'd15,
        UOP_OUT_RD   = 5'd16,
        UOP_OUT_LD   = 5'd17
    } t_uop;

    typedef enum logic [1:0] {
        OP_SEED = 2'd0,
        OP_INIT = 2'd1,
        OP_NEXT = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef struct packed {
        t_uop       uop;
        logic [2:0] row;   // scramble row
        logic       pass;  // 0: seeds from page store, 1: pool
    } t_cmd;

    typedef struct packed {
        logic page_empty;
        logic out_free;
    } t_status;

    // one row of the key scramble: v0 ^ shifted v1
    function automatic logic [31:0] scr_mix(input logic [31:0] v0, input logic [31:0] v1,
                                            input logic [2:0] row);
        logic [31:0] t;
        case (row)
            3'd0:    t = v1 << 11;
            3'd1:    t = v1 >> 2;
            3'd2:    t = v1 << 8;
            3'd3:    t = v1 >> 16;
            3'd4:    t = v1 << 10;
            3'd5:    t = v1 >> 4;
            3'd6:    t = v1 << 8;
            default: t = v1 >> 9;
        endcase
        return v0 ^ t;
    endfunction

    // page generation accumulator mix, chosen by word index mod 4
    function automatic logic [31:0] acc_mix(input logic [31:0] a, input logic [1:0] sel);
        logic [31:0] t;
        case (sel)
            2'd0:    t = a << 13;
            2'd1:    t = a >> 6;
            2'd2:    t = a << 2;
            default: t = a >> 16;
        endcase
        return a ^ t;
    endfunction

endpackage

// ----- rtl/iksg_ram.sv -----
module iksg_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/iksg_ctrl.sv -----
module iksg_ctrl #(
    parameter int POOL_LOG2 = iksg_pkg::POOL_LOG2_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_op,
    output logic                 o_in_ready,
    input  iksg_pkg::t_status    i_status,
    output iksg_pkg::t_cmd       o_cmd,
    output logic [POOL_LOG2-1:0] o_cnt
);
    import iksg_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_SEED  = 20'h00002,
        S_INIT  = 20'h00004,
        S_WARM  = 20'h00008,
        S_LD_RD = 20'h00010,
        S_LD_AD = 20'h00020,
        S_SCR   = 20'h00040,
        S_ST    = 20'h00080,
        S_MP0   = 20'h00100,
        S_MP1   = 20'h00200,
        S_MP2   = 20'h00400,
        S_MP3   = 20'h00800,
        S_MP4   = 20'h01000,
        S_MP5   = 20'h02000,
        S_MP6   = 20'h04000,
        S_MPEND = 20'h08000,
        S_CLRW  = 20'h10000,
        S_NXCHK = 20'h20000,
        S_NXRD  = 20'h40000,
        S_NXOUT = 20'h80000
    } t_state;

    t_state               r_state, n_state;
    logic [POOL_LOG2-1:0] r_cnt, n_cnt;
    logic [2:0]           r_row, n_row;
    logic [1:0]           r_rep, n_rep;
    logic                 r_pass, n_pass;
    logic                 r_init, n_init;
    t_op                  w_op;

    assign w_op = t_op'(i_op);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_row   = r_row;
        n_rep   = r_rep;
        n_pass  = r_pass;
        n_init  = r_init;
        o_cmd   = '{uop: UOP_NONE, row: r_row, pass: r_pass};
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (w_op)
                        OP_SEED: n_state = S_SEED;
                        OP_INIT: n_state = S_INIT;
                        OP_NEXT: n_state = S_NXCHK;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEED: begin
                o_cmd.uop = UOP_SEED_WR;
                n_state   = S_IDLE;
            end
            S_INIT: begin
                o_cmd.uop = UOP_INIT_CLR;
                n_cnt     = '0;
                n_row     = '0;
                n_rep     = '0;
                n_pass    = 1'b0;
                n_init    = 1'b1;
                n_state   = S_WARM;
            end
            S_WARM: begin
                o_cmd.uop = UOP_SCR_ROW;
                n_row     = r_row + 3'd1;
                if (&r_row) begin
                    n_rep = r_rep + 2'd1;
                    if (&r_rep) begin
                        n_state = S_LD_RD;
                    end
                end
            end
            S_LD_RD: begin
                o_cmd.uop = UOP_LD_RD;
                n_state   = S_LD_AD;
            end
            S_LD_AD: begin
                o_cmd.uop  = UOP_LD_ADD;
                n_cnt[2:0] = r_cnt[2:0] + 3'd1;
                n_state    = (&r_cnt[2:0]) ? S_SCR : S_LD_RD;
            end
            S_SCR: begin
                o_cmd.uop = UOP_SCR_ROW;
                n_row     = r_row + 3'd1;
                if (&r_row) begin
                    n_state = S_ST;
                end
            end
            S_ST: begin
                o_cmd.uop = UOP_ST;
                if (&r_cnt[2:0]) begin
                    n_cnt = r_cnt + 1'b1;
                    if (&r_cnt) begin
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_state = S_LD_RD;
                        end else begin
                            n_state = S_MP0;
                        end
                    end else begin
                        n_state = S_LD_RD;
                    end
                end else begin
                    n_cnt[2:0] = r_cnt[2:0] + 3'd1;
                end
            end
            S_MP0: begin
                o_cmd.uop = UOP_MP_START;
                n_cnt     = '0;
                n_state   = S_MP1;
            end
            S_MP1: begin
                o_cmd.uop = UOP_MP1;
                n_state   = S_MP2;
            end
            S_MP2: begin
                o_cmd.uop = UOP_MP2;
                n_state   = S_MP3;
            end
            S_MP3: begin
                o_cmd.uop = UOP_MP3;
                n_state   = S_MP4;
            end
            S_MP4: begin
                o_cmd.uop = UOP_MP4;
                n_state   = S_MP5;
            end
            S_MP5: begin
                o_cmd.uop = UOP_MP5;
                n_state   = S_MP6;
            end
            S_MP6: begin
                o_cmd.uop = UOP_MP6;
                n_cnt     = r_cnt + 1'b1;
                n_state   = (&r_cnt) ? S_MPEND : S_MP1;
            end
            S_MPEND: begin
                o_cmd.uop = UOP_MP_END;
                n_state   = r_init ? S_CLRW : S_NXRD;
            end
            S_CLRW: begin
                o_cmd.uop = UOP_CLR_WR;
                n_init    = 1'b0;
                n_state   = S_IDLE;
            end
            S_NXCHK: begin
                n_state = i_status.page_empty ? S_MP0 : S_NXRD;
            end
            S_NXRD: begin
                o_cmd.uop = UOP_OUT_RD;
                n_state   = S_NXOUT;
            end
            S_NXOUT: begin
                if (i_status.out_free) begin
                    o_cmd.uop = UOP_OUT_LD;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_row   <= '0;
            r_rep   <= '0;
            r_pass  <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_rep   <= n_rep;
            r_pass  <= n_pass;
            r_init  <= n_init;
        end
    end

    assign o_cnt = r_cnt;
endmodule

// ----- rtl/iksg_dp.sv -----
module iksg_dp #(
    parameter int POOL_LOG2 = iksg_pkg::POOL_LOG2_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_acc,
    input  logic [7:0]           i_seed_index,
    input  logic [31:0]          i_seed_word,
    input  iksg_pkg::t_cmd       i_cmd,
    input  logic [POOL_LOG2-1:0] i_cnt,
    output iksg_pkg::t_status    o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_sequence_number,
    output logic [31:0]          o_random_word
);
    import iksg_pkg::*;

    localparam int L = POOL_LOG2;
    localparam int N = 1 << L;

    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic [31:0]  r_acc_a, n_acc_a, r_acc_b, n_acc_b;
    logic [31:0]  r_page_count, n_page_count, r_seq, n_seq;
    logic [L:0]   r_read_pos, n_read_pos;
    logic [N-1:0] r_written;
    logic         r_wbit;
    logic [L-1:0] r_idx;
    logic [31:0]  r_word, r_x, r_y;
    logic         r_out_valid;
    logic [31:0]  r_out_seq, r_out_word;

    logic         w_pool_we, w_pool_re, w_page_we, w_page_re;
    logic [L-1:0] w_pool_wa, w_pool_ra, w_page_wa, w_page_ra;
    logic [31:0]  w_pool_wd, w_page_wd, w_pool_rd, w_page_rd;
    logic [31:0]  w_t [8];
    logic [31:0]  w_add, w_y;

    iksg_ram #(.WIDTH(32), .DEPTH(N)) u_pool (
        .i_clk(i_clk), .i_we(w_pool_we), .i_waddr(w_pool_wa), .i_wdata(w_pool_wd),
        .i_re(w_pool_re), .i_raddr(w_pool_ra), .o_rdata(w_pool_rd)
    );

    iksg_ram #(.WIDTH(32), .DEPTH(N)) u_page (
        .i_clk(i_clk), .i_we(w_page_we), .i_waddr(w_page_wa), .i_wdata(w_page_wd),
        .i_re(w_page_re), .i_raddr(w_page_ra), .o_rdata(w_page_rd)
    );

    assign w_add = i_cmd.pass ? w_pool_rd : (r_wbit ? w_page_rd : 32'd0);
    assign w_y   = w_pool_rd + r_acc_a + r_acc_b;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_t[j] = r_v[j];
            n_v[j] = r_v[j];
        end
        n_acc_a      = r_acc_a;
        n_acc_b      = r_acc_b;
        n_page_count = r_page_count;
        n_seq        = r_seq;
        n_read_pos   = r_read_pos;
        w_pool_we = 1'b0; w_pool_wa = i_cnt; w_pool_wd = r_v[0];
        w_pool_re = 1'b0; w_pool_ra = i_cnt;
        w_page_we = 1'b0; w_page_wa = i_cnt; w_page_wd = w_pool_rd + r_x;
        w_page_re = 1'b0; w_page_ra = i_cnt;
        case (i_cmd.uop)
            UOP_SEED_WR: begin
                w_page_we = 1'b1;
                w_page_wa = r_idx;
                w_page_wd = r_word;
            end
            UOP_INIT_CLR: begin
                for (int j = 0; j < 8; j++) n_v[j] = GOLDEN;
                n_acc_a      = '0;
                n_acc_b      = '0;
                n_page_count = '0;
                n_seq        = '0;
                n_read_pos   = '0;
            end
            UOP_SCR_ROW: begin
                // row on positions 0..3, then rotate so the next row is at 0 again
                w_t[0] = scr_mix(r_v[0], r_v[1], i_cmd.row);
                w_t[3] = r_v[3] + w_t[0];
                w_t[1] = r_v[1] + r_v[2];
                for (int j = 0; j < 8; j++) n_v[j] = w_t[(j + 1) % 8];
            end
            UOP_LD_RD: begin
                w_pool_re = i_cmd.pass;
                w_page_re = !i_cmd.pass;
            end
            UOP_LD_ADD: begin
                w_t[0] = r_v[0] + w_add;
                for (int j = 0; j < 8; j++) n_v[j] = w_t[(j + 1) % 8];
            end
            UOP_ST: begin
                w_pool_we = 1'b1;
                for (int j = 0; j < 8; j++) n_v[j] = r_v[(j + 1) % 8];
            end
            UOP_MP_START: begin
                n_page_count = r_page_count + 32'd1;
                n_acc_b      = r_acc_b + r_page_count + 32'd1;
            end
            UOP_MP1: w_pool_re = 1'b1;
            UOP_MP2: begin
                w_pool_re = 1'b1;
                w_pool_ra = {~i_cnt[L-1], i_cnt[L-2:0]};
            end
            UOP_MP3: begin
                n_acc_a   = acc_mix(r_acc_a, i_cnt[1:0]) + w_pool_rd;
                w_pool_re = 1'b1;
                w_pool_ra = r_x[2 +: L];
            end
            UOP_MP4: begin
                w_pool_we = 1'b1;
                w_pool_wd = w_y;
            end
            UOP_MP5: begin
                w_pool_re = 1'b1;
                w_pool_ra = r_y[L + 2 +: L];
            end
            UOP_MP6: begin
                w_page_we = 1'b1;
                n_acc_b   = w_pool_rd + r_x;
            end
            UOP_MP_END: n_read_pos = '0;
            UOP_OUT_RD: begin
                w_page_re = 1'b1;
                w_page_ra = r_read_pos[L-1:0];
            end
            UOP_OUT_LD: begin
                n_read_pos = r_read_pos + 1'b1;
                n_seq      = r_seq + 32'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_a      <= '0;
            r_acc_b      <= '0;
            r_page_count <= '0;
            r_seq        <= '0;
            r_read_pos   <= '0;
            r_written    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_acc_a      <= n_acc_a;
            r_acc_b      <= n_acc_b;
            r_page_count <= n_page_count;
            r_seq        <= n_seq;
            r_read_pos   <= n_read_pos;
            if (i_cmd.uop == UOP_SEED_WR) begin
                r_written[r_idx] <= 1'b1;
            end else if (i_cmd.uop == UOP_CLR_WR) begin
                r_written <= '0;
            end
            if (i_cmd.uop == UOP_OUT_LD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) r_v[j] <= n_v[j];
        if (i_in_acc) begin
            r_idx  <= L'(i_seed_index);
            r_word <= i_seed_word;
        end
        if (i_cmd.uop == UOP_LD_RD) begin
            r_wbit <= r_written[i_cnt];
        end
        if (i_cmd.uop == UOP_MP2) begin
            r_x <= w_pool_rd;
        end
        if (i_cmd.uop == UOP_MP4) begin
            r_y <= w_y;
        end
        if (i_cmd.uop == UOP_OUT_LD) begin
            r_out_seq  <= r_seq;
            r_out_word <= w_page_rd;
        end
    end

    assign o_status.page_empty = r_read_pos[L];
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_sequence_number   = r_out_seq;
    assign o_random_word       = r_out_word;
endmodule

// ----- rtl/isaac_keyed_sequence_generator_core.sv -----
// ISAAC keyed sequence generator. Commands arrive as beats on the slave
// stream: op 0 stores a packed seed word at seed_index (taken modulo the pool
// size), op 1 rebuilds the generator from the stored seeds (unwritten slots
// count as zero) and makes the first page, op 2 returns one beat on the
// master stream holding the running sequence number and the next page word,
// op 3 is ignored. Issue op 1 before the first op 2. One command is worked at
// a time; the output register lets a result wait while the next command is
// taken. With N = 2^POOL_LOG2 pool words, op 2 runs accept, check, page RAM
// read, load output (held until the output register is free), and an op 2
// that finds the page used up (the (N+1)-th after op 1, then every N-th)
// first regenerates the page, each word running through steps MP1 to MP6
// of pool and page RAM reads and writes. Op 1 runs accept and clear, 32
// rows of warm-up scramble, two passes over the 8-word blocks (loads, 8
// scramble rows, stores), one page build, then the seed-flag clear.
module isaac_keyed_sequence_generator_core #(
    parameter int POOL_LOG2 = iksg_pkg::POOL_LOG2_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [1:0] op, [9:2] seed_index, [41:10] seed_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [31:0] sequence_number, [63:32] random_word
);
    import iksg_pkg::*;

    t_cmd                 w_cmd;
    t_status              w_status;
    logic [POOL_LOG2-1:0] w_cnt;
    logic                 w_in_acc;
    logic [31:0]          w_seq, w_word;

    assign w_in_acc = i_s_tvalid && o_s_tready;

    iksg_ctrl #(.POOL_LOG2(POOL_LOG2)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_op       (i_s_tdata[1:0]),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_cnt      (w_cnt)
    );

    iksg_dp #(.POOL_LOG2(POOL_LOG2)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_acc          (w_in_acc),
        .i_seed_index      (i_s_tdata[9:2]),
        .i_seed_word       (i_s_tdata[41:10]),
        .i_cmd             (w_cmd),
        .i_cnt             (w_cnt),
        .o_status          (w_status),
        .o_out_valid       (o_m_tvalid),
        .i_out_ready       (i_m_tready),
        .o_sequence_number (w_seq),
        .o_random_word     (w_word)
    );

    assign o_m_tdata = {w_word, w_seq};

    // a real command keeps the controller busy in the next cycle
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tdata[1:0] != OP_NOP) |=> !o_s_tready)
        else $error("ready high right after a command");

    // while idle, no datapath operation runs
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (w_cmd.uop == UOP_NONE))
        else $error("datapath op while idle");

    // a pending result blocks loading another one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> (w_cmd.uop != UOP_OUT_LD))
        else $error("result overwritten");
endmodule

// ----- test/iksg_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams, models the generator and compares every output beat.
module iksg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,   // [1:0] op, [9:2] seed_index, [41:10] seed_word
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // [31:0] sequence_number, [63:32] random_word
    output int          o_errors,
    output int          o_pending
);
    import iksg_pkg::*;

    localparam int WORDS = 1 << POOL_LOG2_DEF;
    localparam int HALF  = WORDS / 2;

    typedef struct {
        logic [31:0] seq_num;
        logic [31:0] rand_word;
    } t_gen_out;

    t_gen_out    gen_out_q[$];
    logic [31:0] page_mem[WORDS];
    logic [31:0] pool_mem[WORDS];
    bit          seeded[WORDS];
    logic [31:0] mix_v[8];
    logic [31:0] acc_a, acc_b, page_cnt, seq_cnt;
    int          rd_pos;

    initial begin
        o_errors = 0;
        foreach (seeded[k]) seeded[k] = 0;
        acc_a = 0; acc_b = 0; page_cnt = 0; seq_cnt = 0; rd_pos = 0;
    end

    assign o_pending = gen_out_q.size();

    function automatic logic [31:0] pool_lookup(input logic [31:0] v);
        return pool_mem[(v >> 2) & (WORDS - 1)];
    endfunction

    task automatic scramble_v();
        mix_v[0] ^= mix_v[1] << 11; mix_v[3] += mix_v[0]; mix_v[1] += mix_v[2];
        mix_v[1] ^= mix_v[2] >> 2;  mix_v[4] += mix_v[1]; mix_v[2] += mix_v[3];
        mix_v[2] ^= mix_v[3] << 8;  mix_v[5] += mix_v[2]; mix_v[3] += mix_v[4];
        mix_v[3] ^= mix_v[4] >> 16; mix_v[6] += mix_v[3]; mix_v[4] += mix_v[5];
        mix_v[4] ^= mix_v[5] << 10; mix_v[7] += mix_v[4]; mix_v[5] += mix_v[6];
        mix_v[5] ^= mix_v[6] >> 4;  mix_v[0] += mix_v[5]; mix_v[6] += mix_v[7];
        mix_v[6] ^= mix_v[7] << 8;  mix_v[1] += mix_v[6]; mix_v[7] += mix_v[0];
        mix_v[7] ^= mix_v[0] >> 9;  mix_v[2] += mix_v[7]; mix_v[0] += mix_v[1];
    endtask

    task automatic build_page();
        logic [31:0] a, b, x, y, t;
        a = acc_a;
        page_cnt += 1;
        b = acc_b + page_cnt;
        for (int i = 0; i < WORDS; i++) begin
            x = pool_mem[i];
            case (i % 4)
                0:       t = a << 13;
                1:       t = a >> 6;
                2:       t = a << 2;
                default: t = a >> 16;
            endcase
            a = (a ^ t) + pool_mem[(i + HALF) % WORDS];
            y = pool_lookup(x) + a + b;
            pool_mem[i] = y;
            b = pool_lookup(y >> POOL_LOG2_DEF) + x;
            page_mem[i] = b;
        end
        acc_a = a;
        acc_b = b;
        rd_pos = 0;
    endtask

    task automatic rebuild();
        acc_a = 0; acc_b = 0; page_cnt = 0; rd_pos = 0; seq_cnt = 0;
        foreach (mix_v[j]) mix_v[j] = GOLDEN;
        repeat (4) scramble_v();
        // first pass takes seeds (unwritten slots as zero), second the pool
        for (int i = 0; i < WORDS; i += 8) begin
            for (int j = 0; j < 8; j++) mix_v[j] += seeded[i + j] ? page_mem[i + j] : 32'd0;
            scramble_v();
            for (int j = 0; j < 8; j++) pool_mem[i + j] = mix_v[j];
        end
        for (int i = 0; i < WORDS; i += 8) begin
            for (int j = 0; j < 8; j++) mix_v[j] += pool_mem[i + j];
            scramble_v();
            for (int j = 0; j < 8; j++) pool_mem[i + j] = mix_v[j];
        end
        build_page();
        foreach (seeded[k]) seeded[k] = 0;
    endtask

    always @(posedge i_clk) begin
        t_gen_out exp_beat;
        t_op      op;
        if (i_rst_n) begin
            // output side first: a beat leaving now belongs to an older command
            if (i_m_tvalid && i_m_tready) begin
                if (gen_out_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: output beat %h with nothing expected", $realtime,
                                 i_m_tdata);
                end else begin
                    exp_beat = gen_out_q.pop_front();
                    if (i_m_tdata[31:0] !== exp_beat.seq_num
                            || i_m_tdata[63:32] !== exp_beat.rand_word) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: seq exp %h got %h, word exp %h got %h", $realtime,
                                     exp_beat.seq_num, i_m_tdata[31:0],
                                     exp_beat.rand_word, i_m_tdata[63:32]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                op = t_op'(i_s_tdata[1:0]);
                case (op)
                    OP_SEED: begin
                        page_mem[i_s_tdata[9:2] % WORDS] = i_s_tdata[41:10];
                        seeded[i_s_tdata[9:2] % WORDS] = 1;
                    end
                    OP_INIT: rebuild();
                    OP_NEXT: begin
                        if (rd_pos >= WORDS) build_page();
                        exp_beat.seq_num   = seq_cnt;
                        exp_beat.rand_word = page_mem[rd_pos];
                        rd_pos++;
                        seq_cnt++;
                        gen_out_q.push_back(exp_beat);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import iksg_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [1:0] op, [9:2] seed_index, [41:10] seed_word
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;        // [31:0] sequence_number, [63:32] random_word
    int          errors, pending;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;           // asks the receiver for one long back-pressure stretch
    bit  init_seen = 0;          // no next request may precede the first initialize

    isaac_keyed_sequence_generator_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    iksg_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop; a correct run needs well under a tenth of this.
    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here on request.
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            if (hold_req && hold_cnt == 0) begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // One command beat; valid stays up across back-to-back beats.
    task automatic send_cmd(input t_op op, input logic [7:0] idx, input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {6'd0, word, idx, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_INIT) init_seen = 1;
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(0, 999);
        if (r < 8)
            send_cmd(OP_INIT, 8'($urandom), $urandom);
        else if (r < 180 || !init_seen)
            send_cmd(OP_SEED, 8'($urandom), $urandom);
        else if (r < 200)
            send_cmd(OP_NOP, 8'($urandom), $urandom);
        else
            send_cmd(OP_NEXT, 8'($urandom), $urandom);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: seed extremes, unused op, initialize, next, rewrite after init
        send_cmd(OP_SEED, 8'd0,   32'h0000_0000);
        send_cmd(OP_SEED, 8'd255, 32'hffff_ffff);
        send_cmd(OP_SEED, 8'd7,   32'h8000_0001);
        send_cmd(OP_NOP,  8'hff,  32'hffff_ffff);
        send_cmd(OP_INIT, 8'd0,   32'd0);
        repeat (5) send_cmd(OP_NEXT, 8'd0, 32'd0);
        // overwrite page words still ahead of the read position
        send_cmd(OP_SEED, 8'd6,   32'h1234_5678);
        send_cmd(OP_SEED, 8'd5,   32'hdead_beef);
        send_cmd(OP_NEXT, 8'hff,  32'hffff_ffff);
        send_cmd(OP_NEXT, 8'd0,   32'd0);
        // re-init sees only the two seeds written since the last one
        send_cmd(OP_INIT, 8'd0,   32'd0);
        repeat (4) send_cmd(OP_NEXT, 8'd0, 32'd0);
        send_cmd(OP_NOP,  8'd0,   32'd0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (phase == 0) begin
                // long back-pressure while requests keep coming; runs past one page
                hold_req = 1;
                repeat (300) send_cmd(OP_NEXT, 8'($urandom), $urandom);
            end
            for (int n = 0; n < 400; n++) begin
                send_random();
                // quiet stretch once in a while, sender waits for the pipe to empty
                if (n == 200) drain();
            end
        end

        drain();
        repeat (4000) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
